>>> src/dprm_pkg.sv
// Package with shared constants and register indexes of the debounced pulse rate meter.
package dprm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  localparam int LIMIT_W   = 7;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int PULSES_W  = 16;
  localparam int ELAPSED_W = 31;
  localparam int RATE_W    = 26;
  localparam int INTEG_W   = 8;
  localparam int SCALE_W   = 30;

  localparam logic [SCALE_W-1:0] RATE_SCALE = 30'd600000000;
  localparam logic [RATE_W-1:0]  RATE_MAX   = '1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 7'd10;
  localparam logic [CFG_W-1:0]   IDLE_RST     = 31'd5000000;
  localparam logic [CFG_W-1:0]   INTERVAL_RST = 31'd1000000;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

endpackage

>>> src/dprm_in_if.sv
// Input channel carrying one sample item: raw level and timestamp.
interface dprm_in_if;
  logic        valid;
  logic        ready;
  logic        sample_level;
  logic [31:0] now_us;

  modport source (output valid, output sample_level, output now_us, input ready);
  modport sink (input valid, input sample_level, input now_us, output ready);
endinterface

>>> src/dprm_out_if.sv
// Output channel carrying one result item: indicator and rate report.
interface dprm_out_if;
  logic        valid;
  logic        ready;
  logic        indicator_on;
  logic        report_valid;
  logic [15:0] reported_pulses;
  logic [30:0] elapsed_us;
  logic [25:0] rate_tenths_per_min;

  modport source (output valid, output indicator_on, output report_valid,
                  output reported_pulses, output elapsed_us, output rate_tenths_per_min,
                  input ready);
  modport sink (input valid, input indicator_on, input report_valid,
                input reported_pulses, input elapsed_us, input rate_tenths_per_min,
                output ready);
endinterface

>>> src/debounced_pulse_rate_meter_unit.sv
// Top level of the debounced pulse rate meter: debouncer, edge counter and serial rate divider.
//
// Each sample item runs through a small sequencer that shares one subtractor. A sample with no
// debounced change passes through accept, filter, idle check and output before its result is
// loaded into the output register. A debounced falling edge passes through accept, filter and
// output, and a debounced rising edge through accept, filter, edge, compare and output. An item
// that makes a rate report also runs the restoring divider, which produces one quotient bit per
// cycle on the shared subtractor. The output register lets the next item be accepted while a
// result still waits. There is no clearing pass after reset.
module debounced_pulse_rate_meter_unit #(
  parameter int COUNT_WIDTH = dprm_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = dprm_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dprm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dprm_pkg::CFG_W-1:0]     cfg_data,
  dprm_in_if.sink                        sample,
  dprm_out_if.source                     result
);
  import dprm_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int CW  = COUNT_WIDTH;
  localparam int AW  = ((TW > CFG_W) ? TW : CFG_W) + 1;
  localparam int PW  = CW + SCALE_W;
  localparam int DCW = $clog2(PW);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILT    = 7'b0000010,
    S_IDLECHK = 7'b0000100,
    S_EDGE    = 7'b0001000,
    S_CMP     = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0] limit;
  logic [CFG_W-1:0]   idle_timeout;
  logic [CFG_W-1:0]   report_interval;

  logic signed [INTEG_W-1:0] integ;
  logic                      deb;
  logic                      burst;
  logic [CW-1:0]             count;
  logic [TW-1:0]             ws;

  logic          lvl;
  logic [TW-1:0] now_r;
  logic [TW-1:0] tdiff;
  logic [TW-1:0] el_r;
  logic          change;
  logic          rep;
  logic [CW-1:0] rep_cnt;
  logic [PW-1:0] dvd;
  logic [TW-2:0] rem;
  logic [RATE_W-1:0] quot;
  logic          ovf;
  logic [DCW-1:0] dcnt;
  logic [RATE_W-1:0] rate_r;

  logic ov;

  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_d;
  logic          alu_ge;

  logic signed [INTEG_W-1:0] lim_s;
  logic signed [INTEG_W-1:0] neg_lim_s;
  logic [TW-1:0]     rem_sh;
  logic [RATE_W-1:0] quot_next;
  logic              ovf_next;
  logic [PW-1:0]     prod;
  logic [31:0]       cnt_ext;
  logic              out_free;

  assign lim_s     = signed'({1'b0, limit});
  assign neg_lim_s = -lim_s;
  assign rem_sh    = {rem, dvd[PW-1]};
  assign alu_d     = alu_a - alu_b;
  assign alu_ge    = !alu_d[AW-1];
  assign quot_next = {quot[RATE_W-2:0], alu_ge};
  assign ovf_next  = ovf | quot[RATE_W-1];
  assign prod      = PW'(count) * PW'(RATE_SCALE);
  assign cnt_ext   = 32'(rep_cnt);
  assign out_free  = !ov || result.ready;

  always_comb begin
    change = 1'b0;
    if (lvl) begin
      if (integ >= lim_s && !deb) begin
        change = 1'b1;
      end
    end else begin
      if (integ <= neg_lim_s && deb) begin
        change = 1'b1;
      end
    end
  end

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      S_FILT: begin
        alu_a = AW'(now_r);
        alu_b = AW'(ws);
      end
      S_IDLECHK: begin
        alu_a = AW'(tdiff);
        alu_b = AW'(idle_timeout);
      end
      S_CMP: begin
        alu_a = AW'(el_r);
        alu_b = AW'(report_interval);
      end
      S_DIV: begin
        alu_a = AW'(rem_sh);
        alu_b = AW'(el_r);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign sample.ready = (state == S_IDLE);
  assign result.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit           <= LIMIT_RST;
      idle_timeout    <= IDLE_RST;
      report_interval <= INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LIMIT:    limit           <= cfg_data[LIMIT_W-1:0];
        REG_IDLE:     idle_timeout    <= cfg_data;
        REG_INTERVAL: report_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      ov <= 1'b1;
    end else if (result.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      integ <= '0;
      deb   <= 1'b0;
      burst <= 1'b0;
      count <= '0;
      ws    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            lvl   <= sample.sample_level;
            now_r <= sample.now_us[TW-1:0];
            rep   <= 1'b0;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          tdiff <= alu_d[TW-1:0];
          if (lvl) begin
            if (integ < lim_s) begin
              integ <= integ + 8'sd1;
            end
          end else begin
            if (integ > neg_lim_s) begin
              integ <= integ - 8'sd1;
            end
          end
          if (!change) begin
            state <= S_IDLECHK;
          end else begin
            deb   <= lvl;
            state <= lvl ? S_EDGE : S_OUT;
          end
        end
        S_IDLECHK: begin
          if (burst && !alu_d[TW-1]) begin
            burst <= 1'b0;
            count <= '0;
          end
          state <= S_OUT;
        end
        S_EDGE: begin
          if (!burst) begin
            ws   <= now_r;
            el_r <= '0;
          end else begin
            el_r <= tdiff;
          end
          burst <= 1'b1;
          if (count != '1) begin
            count <= count + 1'b1;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (!el_r[TW-1] && alu_ge) begin
            rep     <= 1'b1;
            rep_cnt <= count;
            dvd     <= prod;
            count   <= '0;
            ws      <= now_r;
            rem     <= '0;
            quot    <= '0;
            ovf     <= 1'b0;
            dcnt    <= DCW'(PW - 1);
            state   <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          rem  <= alu_ge ? alu_d[TW-2:0] : rem_sh[TW-2:0];
          dvd  <= {dvd[PW-2:0], 1'b0};
          quot <= quot_next;
          ovf  <= ovf_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            rate_r <= ovf_next ? RATE_MAX : quot_next;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result.indicator_on        <= burst;
            result.report_valid        <= rep;
            result.reported_pulses     <= rep ? cnt_ext[PULSES_W-1:0] : '0;
            result.elapsed_us          <= rep ? ELAPSED_W'(el_r) : '0;
            result.rate_tenths_per_min <= rep ? rate_r : '0;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/debounced_pulse_rate_meter_unit_test.sv
// Testbench for the debounced pulse rate meter: directed rows, then random checked pulse trains.
module debounced_pulse_rate_meter_unit_test;
  import dprm_pkg::*;

  // A narrow counter checks that the count width is carried through the divider.
  localparam int COUNT_W = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                 indicator;
    logic                 report;
    logic [PULSES_W-1:0]  pulses;
    logic [ELAPSED_W-1:0] elapsed;
    logic [RATE_W-1:0]    rate;
  } meter_reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
    logic                 level;
    logic [31:0]          stamp;
    bit                   fixed;
    meter_reading_t       reading;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dprm_in_if  sample_ch();
  dprm_out_if result_ch();

  debounced_pulse_rate_meter_unit #(
    .COUNT_WIDTH(COUNT_W),
    .TIME_WIDTH (32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sample   (sample_ch),
    .result   (result_ch)
  );

  logic [LIMIT_W-1:0] limit_reg;
  logic [CFG_W-1:0]   idle_reg;
  logic [CFG_W-1:0]   interval_reg;
  logic signed [7:0]  integ_acc;
  logic               deb_level;
  logic               burst_on;
  logic [COUNT_W-1:0] edge_count;
  logic [31:0]        window_start;

  meter_reading_t expected_readings[$];
  meter_reading_t oldest;
  stim_row_t      directed_rows[$];
  logic [31:0]    stamp_now;
  int             sink_hold;
  int             fail_count = 0;
  int             run_cycles;
  bit             no_idling = 1'b0;

  always #2 clk = ~clk;

  function automatic int draw_wait();
    if (no_idling) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic meter_reading_t predict_reading(logic level, logic [31:0] stamp);
    meter_reading_t    r;
    logic signed [8:0] lim;
    logic signed [8:0] acc;
    bit                flip;
    logic [31:0]       span;
    logic [63:0]       quotient;
    r = '0;
    flip = 1'b0;
    lim = $signed({2'b00, limit_reg});
    acc = integ_acc;
    if (level) begin
      if (acc < lim) acc = acc + 9'sd1;
      else if (!deb_level) flip = 1'b1;
    end else begin
      if (acc > -lim) acc = acc - 9'sd1;
      else if (deb_level) flip = 1'b1;
    end
    integ_acc = acc[7:0];
    if (!flip) begin
      span = stamp - (window_start + idle_reg);
      if (burst_on && !span[31]) begin
        burst_on = 1'b0;
        edge_count = '0;
      end
    end else begin
      deb_level = level;
      if (level) begin
        if (!burst_on) window_start = stamp;
        burst_on = 1'b1;
        if (edge_count != '1) edge_count = edge_count + 1'b1;
        span = stamp - window_start;
        if (!span[31] && span >= {1'b0, interval_reg}) begin
          r.report = 1'b1;
          r.pulses = PULSES_W'(edge_count);
          r.elapsed = span[ELAPSED_W-1:0];
          if (span == 0) begin
            r.rate = RATE_MAX;
          end else begin
            quotient = (64'(RATE_SCALE) * 64'(edge_count)) / 64'(span);
            r.rate = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
          end
          edge_count = '0;
          window_start = stamp;
        end
      end
    end
    r.indicator = burst_on;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic stim_row_t sample_row(logic level, logic [31:0] stamp);
    stim_row_t r;
    r = '{ROW_SAMPLE, REG_LIMIT, '0, level, stamp, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t fixed_row(logic level, logic [31:0] stamp,
                                          meter_reading_t reading);
    stim_row_t r;
    r = sample_row(level, stamp);
    r.fixed = 1'b1;
    r.reading = reading;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    stim_row_t r;
    r = '{ROW_WRITE, index, value, 1'b0, '0, 1'b0, '0};
    return r;
  endfunction

  task automatic send_sample(input logic level, input logic [31:0] stamp, input bit fixed,
                             input meter_reading_t reading);
    int             gap;
    meter_reading_t predicted;
    gap = draw_wait();
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample_level <= level;
    sample_ch.now_us <= stamp;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = predict_reading(level, stamp);
    expected_readings.push_back(fixed ? reading : predicted);
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (index)
      REG_LIMIT: limit_reg = value[LIMIT_W-1:0];
      REG_IDLE: idle_reg = value;
      REG_INTERVAL: interval_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [LIMIT_W-1:0] lim, input logic [CFG_W-1:0] idle,
                           input logic [CFG_W-1:0] interval);
    drain_results();
    write_reg(REG_LIMIT, CFG_W'(lim));
    write_reg(REG_IDLE, idle);
    write_reg(REG_INTERVAL, interval);
  endtask

  task automatic emit_random(input logic level, input int unsigned step_max);
    if ($urandom_range(0, 49) == 0) stamp_now += $urandom();
    else stamp_now += $urandom_range(0, step_max);
    if ($urandom_range(0, 31) == 0) no_idling = !no_idling;
    send_sample(level, stamp_now, 1'b0, '0);
  endtask

  // Mostly clean pulses long enough to swing the integrator, with glitches and noise runs.
  task automatic run_phase(input int lim, input logic [CFG_W-1:0] idle,
                           input logic [CFG_W-1:0] interval, input int unsigned step_max,
                           input int n_items);
    int left;
    int run;
    int k;
    bit glitchy;
    configure(LIMIT_W'(lim), idle, interval);
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 3) != 0) begin
        glitchy = ($urandom_range(0, 9) == 0);
        for (int half = 0; half < 2 && left > 0; half++) begin
          run = 2 * lim + 1 + $urandom_range(0, 2);
          for (k = 0; k < run && left > 0; k++) begin
            emit_random((half == 0) ^ (glitchy && $urandom_range(0, 15) == 0), step_max);
            left--;
          end
        end
      end else begin
        run = $urandom_range(1, 2 * lim + 2);
        for (k = 0; k < run && left > 0; k++) begin
          emit_random(1'($urandom_range(0, 1)), step_max);
          left--;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sink_hold = 0;
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result item with none expected: indicator %0d report %0d pulses %0d",
                   $time, result_ch.indicator_on, result_ch.report_valid,
                   result_ch.reported_pulses);
          fail_count++;
        end else begin
          oldest = expected_readings.pop_front();
          check_field("indicator_on", oldest.indicator, result_ch.indicator_on);
          check_field("report_valid", oldest.report, result_ch.report_valid);
          check_field("reported_pulses", oldest.pulses, result_ch.reported_pulses);
          check_field("elapsed_us", oldest.elapsed, result_ch.elapsed_us);
          check_field("rate_tenths_per_min", oldest.rate, result_ch.rate_tenths_per_min);
        end
        sink_hold = draw_wait();
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      result_ch.ready <= (sink_hold == 0);
    end
  end

  initial begin
    for (run_cycles = 0; run_cycles < CYCLE_LIMIT; run_cycles++) @(posedge clk);
    $display("debounced_pulse_rate_meter_unit_test: FAIL");
    $finish;
  end

  initial begin
    int          p;
    int          lim_pick;
    int unsigned intv_pick;
    int unsigned idle_pick;
    cfg_write <= 1'b0;
    cfg_index <= REG_LIMIT;
    cfg_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample_level <= 1'b0;
    sample_ch.now_us <= '0;
    limit_reg = LIMIT_RST;
    idle_reg = IDLE_RST;
    interval_reg = INTERVAL_RST;
    integ_acc = '0;
    deb_level = 1'b0;
    burst_on = 1'b0;
    edge_count = '0;
    window_start = '0;

    // The falling edge at 135 skips the expired idle check; the next sample clears the burst.
    // With a zero interval the first report saturates the rate, the second has zero elapsed.
    directed_rows = '{
      fixed_row(1'b0, 32'd0, meter_reading_t'(0)),
      write_row(REG_LIMIT, 31'd1),
      write_row(REG_IDLE, 31'd100),
      write_row(REG_INTERVAL, 31'd50),
      sample_row(1'b1, 32'd10), sample_row(1'b1, 32'd20), sample_row(1'b1, 32'd30),
      sample_row(1'b0, 32'd40), sample_row(1'b0, 32'd50), sample_row(1'b0, 32'd135),
      sample_row(1'b1, 32'd136), sample_row(1'b1, 32'd140), sample_row(1'b1, 32'd150),
      write_row(REG_INTERVAL, 31'd0),
      sample_row(1'b0, 32'd151), sample_row(1'b0, 32'd152), sample_row(1'b0, 32'd153),
      sample_row(1'b1, 32'd154), sample_row(1'b1, 32'd155),
      fixed_row(1'b1, 32'd156, meter_reading_t'{1'b1, 1'b1, 16'd2, 31'd6, RATE_MAX}),
      sample_row(1'b0, 32'd156), sample_row(1'b0, 32'd156), sample_row(1'b0, 32'd156),
      sample_row(1'b1, 32'd156), sample_row(1'b1, 32'd156),
      fixed_row(1'b1, 32'd156, meter_reading_t'{1'b1, 1'b1, 16'd1, 31'd0, RATE_MAX}),
      sample_row(1'b1, 32'hFFFF_FFFF)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].level, directed_rows[i].stamp, directed_rows[i].fixed,
                    directed_rows[i].reading);
      end
    end
    stamp_now = 32'hFFFF_FFFF;

    run_phase(3, 31'd2000, 31'd500, 40, 40);
    run_phase(1, 31'd1, 31'd1, 3, 40);
    run_phase(2, 31'h7FFF_FFFF, 31'd0, 5, 40);
    run_phase(127, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0100_0000, 400);
    for (p = 0; p < 5; p++) begin
      lim_pick = $urandom_range(1, 6);
      intv_pick = $urandom_range(1, 1 << 20);
      idle_pick = intv_pick * $urandom_range(1, 5);
      run_phase(lim_pick, CFG_W'(idle_pick), CFG_W'(intv_pick),
                intv_pick / (4 * lim_pick + 4) + 1, 40);
    end
    run_phase(int'(LIMIT_RST), IDLE_RST, INTERVAL_RST, 40000, 60);

    drain_results();
    if (fail_count == 0) begin
      $display("debounced_pulse_rate_meter_unit_test: PASS");
    end else begin
      $display("debounced_pulse_rate_meter_unit_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dprm_pkg.sv
src/dprm_in_if.sv
src/dprm_out_if.sv
src/debounced_pulse_rate_meter_unit.sv
dv/debounced_pulse_rate_meter_unit_test.sv
